// ===== design/spcs_pkg.sv =====
// Shared types and constants for the strict-priority call server.
package spcs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CLASSES = 4;

    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 2;
    localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] dur;
    } t_call;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [1:0] cls;
        t_call      call;
    } t_req;

    typedef struct packed {
        logic             avail;
        logic [CLS_W-1:0] cls;
        t_call            call;
    } t_pick;

endpackage

// ===== design/spcs_queues.sv =====
// Per-class FIFO queues with prefetched head entries and priority pick.
module spcs_queues
    import spcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  logic  i_srv_busy,
    output t_pick o_pick,
    output logic  o_drop,
    output logic  o_empty_next
);

    logic [23:0]      mem [STORE_DEPTH];
    t_call            r_rdata;
    logic             r_pend;
    logic [CLS_W-1:0] r_pend_cls;
    logic             n_pend;

    t_call            r_hd    [NUM_CLASSES];
    t_call            n_hd    [NUM_CLASSES];
    logic [PTR_W-1:0] r_head  [NUM_CLASSES];
    logic [PTR_W-1:0] n_head  [NUM_CLASSES];
    logic [CNT_W-1:0] r_count [NUM_CLASSES];
    logic [CNT_W-1:0] n_count [NUM_CLASSES];

    t_call            eff [NUM_CLASSES];
    logic [CLS_W-1:0] a_cls;
    logic             cls_ok;
    logic             arrive;
    logic             wr_en;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail_pos;
    logic [ADDR_W-1:0] wr_addr;
    logic             pop;
    logic [PTR_W-1:0] pop_head;
    logic [ADDR_W-1:0] rd_addr;

    // Head of a class that was just refilled still sits in the read register.
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            eff[c] = (r_pend && (r_pend_cls == CLS_W'(c))) ? r_rdata : r_hd[c];
        end
    end

    always_comb begin
        o_pick = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_count[c] != '0) begin
                o_pick.avail = 1'b1;
                o_pick.cls   = CLS_W'(c);
                o_pick.call  = eff[c];
            end
        end
    end

    assign a_cls    = CLS_W'(i_req.cls);
    assign cls_ok   = (int'(i_req.cls) < NUM_CLASSES);
    assign arrive   = i_req.valid && (i_req.kind == KIND_ARRIVAL);
    assign o_drop   = arrive && (!cls_ok || (r_count[a_cls] == CNT_W'(QUEUE_DEPTH)));
    assign wr_en    = arrive && !o_drop;
    assign tail_sum = SUM_W'(r_head[a_cls]) + SUM_W'(r_count[a_cls]);
    assign tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign wr_addr  = ADDR_W'(a_cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);

    assign pop      = i_req.valid && (i_req.kind == KIND_TICK) && !i_srv_busy && o_pick.avail;
    assign pop_head = (r_head[o_pick.cls] == PTR_W'(QUEUE_DEPTH - 1)) ?
                      '0 : r_head[o_pick.cls] + PTR_W'(1);
    assign rd_addr  = ADDR_W'(o_pick.cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pop_head);
    assign n_pend   = pop && (r_count[o_pick.cls] > CNT_W'(1));

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_hd[c]    = r_hd[c];
            n_head[c]  = r_head[c];
            n_count[c] = r_count[c];
        end
        if (r_pend) begin
            n_hd[r_pend_cls] = r_rdata;
        end
        if (wr_en) begin
            n_count[a_cls] = r_count[a_cls] + CNT_W'(1);
            if (r_count[a_cls] == '0) begin
                n_hd[a_cls] = i_req.call;
            end
        end
        if (pop) begin
            n_head[o_pick.cls]  = pop_head;
            n_count[o_pick.cls] = r_count[o_pick.cls] - CNT_W'(1);
        end
    end

    always_comb begin
        o_empty_next = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (n_count[c] != '0) begin
                o_empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_req.call;
        end
        if (pop) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            r_hd[c] <= n_hd[c];
        end
        r_pend_cls <= o_pick.cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
        end else begin
            r_pend <= n_pend;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= n_head[c];
                r_count[c] <= n_count[c];
            end
        end
    end

    // A refill is only pending for a class that still holds calls.
    a_pend_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_count[r_pend_cls] != '0))
        else $error("refill pending on empty class");

    // A pop issues a refill exactly when the class keeps calls afterwards.
    a_pend_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (r_count[o_pick.cls] > CNT_W'(1))) |=> r_pend)
        else $error("missing head refill after pop");

endmodule

// ===== design/spcs_server.sv =====
// Server state, tick counter and result register.
module spcs_server
    import spcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  t_pick       i_pick,
    input  logic        i_drop,
    input  logic        i_empty_next,
    output logic        o_srv_busy,
    output logic        o_valid,
    output logic [31:0] o_tick_number,
    output logic        o_answered,
    output logic [7:0]  o_answered_id,
    output logic [1:0]  o_answered_class,
    output logic        o_finished,
    output logic [7:0]  o_finished_id,
    output logic        o_arrival_dropped,
    output logic        o_all_idle
);

    logic        r_busy, n_busy;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_dur, n_dur;
    logic [15:0] r_tis, n_tis;
    logic [31:0] r_tick, n_tick;

    logic        ans, fin;
    logic [7:0]  ans_id, fin_id;
    logic [1:0]  ans_cls;

    logic        r_valid;
    logic [31:0] r_tick_number;
    logic        r_answered;
    logic [7:0]  r_answered_id;
    logic [1:0]  r_answered_class;
    logic        r_finished;
    logic [7:0]  r_finished_id;
    logic        r_dropped;
    logic        r_all_idle;

    always_comb begin
        n_busy  = r_busy;
        n_id    = r_id;
        n_dur   = r_dur;
        n_tis   = r_tis;
        n_tick  = r_tick;
        ans     = 1'b0;
        ans_id  = '0;
        ans_cls = '0;
        fin     = 1'b0;
        fin_id  = '0;
        if (i_req.valid && (i_req.kind == KIND_TICK)) begin
            if (!r_busy && i_pick.avail) begin
                n_busy  = 1'b1;
                n_id    = i_pick.call.id;
                n_dur   = i_pick.call.dur;
                n_tis   = '0;
                ans     = 1'b1;
                ans_id  = i_pick.call.id;
                ans_cls = 2'(i_pick.cls);
            end
            if (n_busy) begin
                // may finish on the answering tick
                if (({1'b0, n_tis} + 17'd1) >= {1'b0, n_dur}) begin
                    fin    = 1'b1;
                    fin_id = n_id;
                    n_busy = 1'b0;
                    n_tis  = '0;
                end else begin
                    n_tis = n_tis + 16'd1;
                end
            end
            n_tick = r_tick + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_id    <= '0;
            r_dur   <= '0;
            r_tis   <= '0;
            r_tick  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_id    <= n_id;
            r_dur   <= n_dur;
            r_tis   <= n_tis;
            r_tick  <= n_tick;
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick_number    <= r_tick;
        r_answered       <= ans;
        r_answered_id    <= ans_id;
        r_answered_class <= ans_cls;
        r_finished       <= fin;
        r_finished_id    <= fin_id;
        r_dropped        <= i_drop;
        r_all_idle       <= !n_busy && i_empty_next;
    end

    assign o_srv_busy        = r_busy;
    assign o_valid           = r_valid;
    assign o_tick_number     = r_tick_number;
    assign o_answered        = r_answered;
    assign o_answered_id     = r_answered_id;
    assign o_answered_class  = r_answered_class;
    assign o_finished        = r_finished;
    assign o_finished_id     = r_finished_id;
    assign o_arrival_dropped = r_dropped;
    assign o_all_idle        = r_all_idle;

    // A call in service has not yet reached its duration.
    a_tis_below_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_tis < r_dur))
        else $error("call in service overran its duration");

    // A result strobe always follows an accepted request.
    a_strobe_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_req.valid))
        else $error("result without request");

    // Dropped arrivals never answer or finish a call.
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_arrival_dropped) |-> (!o_answered && !o_finished))
        else $error("drop flagged on a tick result");

    // Answering only happens from an idle server; an idle server answers on any tick with a waiting call.
    a_answer_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && (i_req.kind == KIND_TICK) && !r_busy && i_pick.avail) |=> o_answered)
        else $error("idle server skipped a waiting call");

endmodule

// ===== design/strict_priority_call_server_top.sv =====
// Top level of the strict-priority four-class call server.
// One request is taken per clock: a request is accepted when start is high and
// busy is low, and its result is registered onto the result ports, shown for
// exactly one cycle and flagged by o_valid. busy is high during reset and until r_up
// is set after it; afterwards every cycle can carry a request, since the priority pick
// reads prefetched head entries and the queue memory refills a popped head in the
// cycle after the pop. The receiver must take each result in the cycle it shows.
module strict_priority_call_server_top
    import spcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [1:0]  i_member_class,
    input  logic [7:0]  i_caller_id,
    input  logic [15:0] i_call_duration,
    output logic        o_valid,
    output logic [31:0] o_tick_number,
    output logic        o_answered,
    output logic [7:0]  o_answered_id,
    output logic [1:0]  o_answered_class,
    output logic        o_finished,
    output logic [7:0]  o_finished_id,
    output logic        o_arrival_dropped,
    output logic        o_all_idle
);

    logic  r_up;
    t_req  req;
    t_pick pick;
    logic  drop;
    logic  empty_next;
    logic  srv_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= 1'b0;
        end else begin
            r_up <= 1'b1;
        end
    end

    assign busy          = !r_up;
    assign req.valid     = start && r_up;
    assign req.kind      = i_kind;
    assign req.cls       = i_member_class;
    assign req.call.id   = i_caller_id;
    assign req.call.dur  = i_call_duration;

    spcs_queues u_queues (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_srv_busy   (srv_busy),
        .o_pick       (pick),
        .o_drop       (drop),
        .o_empty_next (empty_next)
    );

    spcs_server u_server (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req),
        .i_pick            (pick),
        .i_drop            (drop),
        .i_empty_next      (empty_next),
        .o_srv_busy        (srv_busy),
        .o_valid           (o_valid),
        .o_tick_number     (o_tick_number),
        .o_answered        (o_answered),
        .o_answered_id     (o_answered_id),
        .o_answered_class  (o_answered_class),
        .o_finished        (o_finished),
        .o_finished_id     (o_finished_id),
        .o_arrival_dropped (o_arrival_dropped),
        .o_all_idle        (o_all_idle)
    );

endmodule
